// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the elevator controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/efc_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator floor controller package
// Widths, codes, reset values and shared types of the controller.
// ----------------------------------------------------------------------------
package efc_pkg;

  localparam int unsigned EFC_FLOOR_W    = 4;
  localparam int unsigned EFC_CNT_W      = 10;
  localparam int unsigned EFC_CFG_IDX_W  = 3;
  localparam int unsigned EFC_FLOORS_DEF = 10;

  typedef logic [EFC_FLOOR_W-1:0] floor_t;
  typedef logic [EFC_CNT_W-1:0]   cnt_t;

  localparam cnt_t EFC_CNT_MAX         = '1;
  localparam cnt_t EFC_UP_BLINK_RST    = 10'd50;
  localparam cnt_t EFC_DOWN_BLINK_RST  = 10'd20;
  localparam cnt_t EFC_UP_FLOOR_RST    = 10'd500;
  localparam cnt_t EFC_DOWN_FLOOR_RST  = 10'd200;
  localparam cnt_t EFC_DOOR_WAIT_RST   = 10'd300;

  typedef enum logic [1:0] {
    MOT_IDLE = 2'd0,
    MOT_UP   = 2'd1,
    MOT_DOWN = 2'd2
  } motion_e;

  typedef enum logic {
    CMD_PRESS = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic [EFC_CFG_IDX_W-1:0] {
    REG_UP_BLINK   = 3'd0,
    REG_DOWN_BLINK = 3'd1,
    REG_UP_FLOOR   = 3'd2,
    REG_DOWN_FLOOR = 3'd3,
    REG_DOOR_WAIT  = 3'd4
  } cfg_idx_e;

  // Timing registers as seen by the update logic.
  typedef struct packed {
    cnt_t up_blink;
    cnt_t down_blink;
    cnt_t up_floor;
    cnt_t down_floor;
    cnt_t door_wait;
  } cfg_t;

  // Car state, apart from the per-floor request bits.
  typedef struct packed {
    floor_t  floor_pos;
    floor_t  target;
    logic    tvalid;
    motion_e motion;
    cnt_t    blink;
    cnt_t    travel;
    cnt_t    door;
    logic    lamp;
  } state_t;

endpackage

// ===== hw/rtl/efc_if.sv =====
// ----------------------------------------------------------------------------
// Elevator controller channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface efc_in_if;
  logic             valid;
  logic             ready;
  logic             command;
  efc_pkg::floor_t  pressed_floor;

  modport source (output valid, output command, output pressed_floor, input ready);
  modport sink   (input valid, input command, input pressed_floor, output ready);
endinterface

interface efc_out_if;
  logic             valid;
  logic             ready;
  efc_pkg::floor_t  floor_now;
  logic [1:0]       motion;
  logic             has_target;
  efc_pkg::floor_t  target_now;
  logic             lamp;
  logic             door_open;

  modport source (output valid, output floor_now, output motion, output has_target,
                  output target_now, output lamp, output door_open, input ready);
  modport sink   (input valid, input floor_now, input motion, input has_target,
                  input target_now, input lamp, input door_open, output ready);
endinterface

// ===== hw/rtl/efc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Elevator controller timing registers
// Five ten-bit timing registers with a plain indexed write port.
// ----------------------------------------------------------------------------
module efc_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [efc_pkg::EFC_CFG_IDX_W-1:0]    cfg_idx_i,
  input  efc_pkg::cnt_t                        cfg_wdata_i,
  output efc_pkg::cfg_t                        cfg_o
);
  import efc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes leave everything as is.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UP_BLINK:   cfg_d.up_blink   = cfg_wdata_i;
        REG_DOWN_BLINK: cfg_d.down_blink = cfg_wdata_i;
        REG_UP_FLOOR:   cfg_d.up_floor   = cfg_wdata_i;
        REG_DOWN_FLOOR: cfg_d.down_floor = cfg_wdata_i;
        REG_DOOR_WAIT:  cfg_d.door_wait  = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_blink   <= EFC_UP_BLINK_RST;
      cfg_q.down_blink <= EFC_DOWN_BLINK_RST;
      cfg_q.up_floor   <= EFC_UP_FLOOR_RST;
      cfg_q.down_floor <= EFC_DOWN_FLOOR_RST;
      cfg_q.door_wait  <= EFC_DOOR_WAIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/efc_step.sv =====
// ----------------------------------------------------------------------------
// Elevator controller update logic
// Next car state for one button press or one tick, in a single pass.
// ----------------------------------------------------------------------------
module efc_step #(
  parameter int unsigned FLOORS = efc_pkg::EFC_FLOORS_DEF
) (
  input  efc_pkg::state_t   state_i,
  input  logic [FLOORS-1:0] req_i,
  input  efc_pkg::cfg_t     cfg_i,
  input  logic              command_i,
  input  efc_pkg::floor_t   pressed_floor_i,
  output efc_pkg::state_t   state_o,
  output logic [FLOORS-1:0] req_o
);
  import efc_pkg::*;

  localparam logic [EFC_FLOOR_W:0] FloorsExt = (EFC_FLOOR_W + 1)'(FLOORS);
  localparam floor_t               TopFloor  = EFC_FLOOR_W'(FLOORS - 1);

  always_comb begin
    state_t            s;
    logic [FLOORS-1:0] r;
    motion_e           dir;
    cnt_t              need;
    logic              pick_hit;
    floor_t            pick;

    s        = state_i;
    r        = req_i;
    dir      = MOT_IDLE;
    need     = '0;
    pick_hit = 1'b0;
    pick     = '0;

    if (command_i == CMD_PRESS) begin
      // Button press: floors past the top are ignored.
      if ({1'b0, pressed_floor_i} < FloorsExt) begin
        if (pressed_floor_i == s.floor_pos) begin
          // Press at the car's floor stops a moving car right here.
          if (s.motion != MOT_IDLE) begin
            s.motion = MOT_IDLE;
            s.door   = cfg_i.door_wait;
            r        = r & ~(FLOORS'(1) << s.floor_pos);
            if (s.tvalid && (s.target == s.floor_pos)) begin
              s.tvalid = 1'b0;
            end
          end
        end else begin
          r = r | (FLOORS'(1) << pressed_floor_i);
          if (!s.tvalid) begin
            s.target = pressed_floor_i;
            s.tvalid = 1'b1;
          end else begin
            // Extend the target along the direction of travel.
            dir = s.motion;
            if (dir == MOT_IDLE) begin
              dir = (s.target > s.floor_pos) ? MOT_UP : MOT_DOWN;
            end
            if ((dir == MOT_UP) && (pressed_floor_i > s.target)) begin
              s.target = pressed_floor_i;
            end else if ((dir == MOT_DOWN) && (pressed_floor_i < s.target)) begin
              s.target = pressed_floor_i;
            end
          end
        end
      end
    end else begin
      // Lamp blink counter, saturating.
      if (s.blink != EFC_CNT_MAX) begin
        s.blink = s.blink + cnt_t'(1);
      end
      if ((s.motion == MOT_UP) && (s.blink >= cfg_i.up_blink)) begin
        s.lamp  = ~s.lamp;
        s.blink = '0;
      end else if ((s.motion == MOT_DOWN) && (s.blink >= cfg_i.down_blink)) begin
        s.lamp  = ~s.lamp;
        s.blink = '0;
      end else if (s.motion == MOT_IDLE) begin
        s.lamp = 1'b1;
      end

      // Travel timing and arrival at a floor.
      if (s.motion != MOT_IDLE) begin
        if (s.travel != EFC_CNT_MAX) begin
          s.travel = s.travel + cnt_t'(1);
        end
        need = (s.motion == MOT_UP) ? cfg_i.up_floor : cfg_i.down_floor;
        if (s.travel >= need) begin
          s.travel = '0;
          if (s.motion == MOT_UP) begin
            if (s.floor_pos < TopFloor) begin
              s.floor_pos = s.floor_pos + floor_t'(1);
            end
          end else begin
            if (s.floor_pos != '0) begin
              s.floor_pos = s.floor_pos - floor_t'(1);
            end
          end
          if (s.tvalid && (s.floor_pos == s.target)) begin
            s.motion = MOT_IDLE;
            s.door   = cfg_i.door_wait;
            r        = r & ~(FLOORS'(1) << s.floor_pos);
            // Lowest pending request becomes the next target.
            for (int i = FLOORS - 1; i >= 0; i--) begin
              if (r[i]) begin
                pick_hit = 1'b1;
                pick     = EFC_FLOOR_W'(i);
              end
            end
            s.tvalid = pick_hit;
            if (pick_hit) begin
              s.target = pick;
            end
          end else if (|(r & (FLOORS'(1) << s.floor_pos))) begin
            s.motion = MOT_IDLE;
            s.door   = cfg_i.door_wait;
            r        = r & ~(FLOORS'(1) << s.floor_pos);
          end
        end
      end

      // Door wait countdown.
      if (s.door != '0) begin
        s.door = s.door - cnt_t'(1);
      end
    end

    // An idle car with a target and a closed door sets off.
    if ((s.motion == MOT_IDLE) && s.tvalid && (s.door == '0)) begin
      if (s.target > s.floor_pos) begin
        s.motion = MOT_UP;
      end else if (s.target < s.floor_pos) begin
        s.motion = MOT_DOWN;
      end
    end

    state_o = s;
    req_o   = r;
  end

endmodule

// ===== hw/rtl/elevator_floor_controller.sv =====
// Single-car elevator controller. Each input word is a button press or one
// 10 ms tick; each accepted word yields exactly one result word carrying the
// car state after that word. An accepted word waits in the input register
// and is then folded into the state register, which also serves as the
// result register, so the result is offered from there; a new word is taken
// every cycle while results are drained. The rate is set by the combinational
// state update path, which includes the lowest-floor request pick. Timing
// registers may be written only while no word is in flight; writes to
// indexes above four are dropped.
// ----------------------------------------------------------------------------
// Elevator floor controller top level
// Input register, car state and result handshake around the update logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elevator_floor_controller #(
  parameter int unsigned FLOORS = efc_pkg::EFC_FLOORS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  efc_in_if.sink                             in_if,
  efc_out_if.source                          out_if,
  input  logic                               cfg_we_i,
  input  logic [efc_pkg::EFC_CFG_IDX_W-1:0]  cfg_idx_i,
  input  efc_pkg::cnt_t                      cfg_wdata_i
);
  import efc_pkg::*;

  cfg_t              cfg;
  logic              in_valid_q;
  logic              in_cmd_q;
  floor_t            in_floor_q;
  logic              out_valid_q;
  logic              step_fire;
  state_t            state_q, state_d;
  logic [FLOORS-1:0] req_q, req_d;

  efc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // A word is processed once the result slot is free or being emptied.
  assign step_fire   = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || step_fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_cmd_q   <= in_if.command;
      in_floor_q <= in_if.pressed_floor;
    end
  end

  efc_step #(
    .FLOORS (FLOORS)
  ) u_step (
    .state_i         (state_q),
    .req_i           (req_q),
    .cfg_i           (cfg),
    .command_i       (in_cmd_q),
    .pressed_floor_i (in_floor_q),
    .state_o         (state_d),
    .req_o           (req_d)
  );

  // Car state; it only moves when a word is processed, so it holds the
  // pending result for as long as that result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step_fire) begin
        state_q <= state_d;
        req_q   <= req_d;
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word.
  assign out_if.valid      = out_valid_q;
  assign out_if.floor_now  = state_q.floor_pos;
  assign out_if.motion     = state_q.motion;
  assign out_if.has_target = state_q.tvalid;
  assign out_if.target_now = state_q.tvalid ? state_q.target : '0;
  assign out_if.lamp       = state_q.lamp;
  assign out_if.door_open  = (state_q.door != '0);

  // An open door always means a stopped car.
  `ASSERT_IMPLIES(a_door_idle, clk_i, rst_ni, state_q.door != '0, state_q.motion == MOT_IDLE)
  // A moving car always has a target.
  `ASSERT_IMPLIES(a_move_target, clk_i, rst_ni, state_q.motion != MOT_IDLE, state_q.tvalid)
  // The car never leaves the shaft.
  `ASSERT_IMPLIES(a_floor_range, clk_i, rst_ni, 1'b1,
                  state_q.floor_pos <= EFC_FLOOR_W'(FLOORS - 1))
  // Every processed word leaves a result behind.
  `ASSERT_NEXT(a_fire_result, clk_i, rst_ni, step_fire, out_valid_q)

endmodule

// ===== bench/elevator_floor_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Elevator floor controller testbench
// Sends button presses and ticks through the input channel with random gaps.
// Each word is also fed to a cycle-free model of the car held in this bench.
// Every result word is compared field by field with the model's prediction.
// Timing registers are reloaded between traffic phases, extremes included.
// ----------------------------------------------------------------------------
module elevator_floor_controller_tb;
  import efc_pkg::*;

  localparam int unsigned FLOORS         = EFC_FLOORS_DEF;
  localparam int unsigned HALF_PERIOD    = 5;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned IDLE_PCT       = 28;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned FLOOR_CODE_MAX = 2 ** EFC_FLOOR_W - 1;
  localparam int unsigned CFG_IDX_SPARE  = int'(REG_DOOR_WAIT) + 1;
  localparam int unsigned CFG_IDX_TOP    = 2 ** EFC_CFG_IDX_W - 1;

  // One result word as the car reports it.
  typedef struct packed {
    floor_t  floor_now;
    motion_e motion;
    logic    has_target;
    floor_t  target_now;
    logic    lamp;
    logic    door_open;
  } car_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                     cfg_we_i;
  logic [EFC_CFG_IDX_W-1:0] cfg_idx_i;
  cnt_t                     cfg_wdata_i;

  efc_in_if  in_ch ();
  efc_out_if out_ch ();

  // Predicted car state and timing registers.
  cfg_t               timing;
  floor_t             car_floor;
  floor_t             car_target;
  logic               car_tv;
  logic [FLOORS-1:0]  car_requests;
  motion_e            car_motion;
  cnt_t               car_blink;
  cnt_t               car_travel;
  cnt_t               car_door;
  logic               car_lamp;

  car_result_t expected_cars [$];
  int          fail_count  = 0;
  int          quiet_cycles = 0;
  bit          steady      = 1'b0;

  elevator_floor_controller #(
    .FLOORS(FLOORS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Stop the car at its floor and start the door wait.
  function automatic void open_door();
    car_motion = MOT_IDLE;
    car_door   = timing.door_wait;
    car_requests[car_floor] = 1'b0;
  endfunction

  // Apply one word to the predicted car and return the state it reports.
  function automatic car_result_t advance_car(input cmd_e cmd, input floor_t fl);
    car_result_t res;
    motion_e     dir;
    cnt_t        need;
    if (cmd == CMD_PRESS) begin
      if (fl < FLOORS) begin
        if (fl == car_floor) begin
          // A press at the car's own floor only matters while it moves.
          if (car_motion != MOT_IDLE) begin
            open_door();
            if (car_tv && car_target == car_floor) car_tv = 1'b0;
          end
        end else begin
          car_requests[fl] = 1'b1;
          if (!car_tv) begin
            car_target = fl;
            car_tv     = 1'b1;
          end else begin
            dir = car_motion;
            if (dir == MOT_IDLE) dir = (car_target > car_floor) ? MOT_UP : MOT_DOWN;
            if (dir == MOT_UP && fl > car_target) car_target = fl;
            else if (dir == MOT_DOWN && fl < car_target) car_target = fl;
          end
        end
      end
    end else begin
      // Lamp blink; the counter runs even while idle and saturates.
      if (car_blink < EFC_CNT_MAX) car_blink++;
      if (car_motion == MOT_UP && car_blink >= timing.up_blink) begin
        car_lamp  = ~car_lamp;
        car_blink = '0;
      end else if (car_motion == MOT_DOWN && car_blink >= timing.down_blink) begin
        car_lamp  = ~car_lamp;
        car_blink = '0;
      end else if (car_motion == MOT_IDLE) begin
        car_lamp = 1'b1;
      end
      // Travel time, floor step and stop decision.
      if (car_motion != MOT_IDLE) begin
        if (car_travel < EFC_CNT_MAX) car_travel++;
        need = (car_motion == MOT_UP) ? timing.up_floor : timing.down_floor;
        if (car_travel >= need) begin
          car_travel = '0;
          if (car_motion == MOT_UP) begin
            if (car_floor < floor_t'(FLOORS - 1)) car_floor++;
          end else begin
            if (car_floor > 0) car_floor--;
          end
          if (car_tv && car_floor == car_target) begin
            open_door();
            car_tv = 1'b0;
            // The lowest pending request becomes the next target.
            for (int i = 0; i < FLOORS; i++) begin
              if (car_requests[i]) begin
                car_target = floor_t'(i);
                car_tv     = 1'b1;
                break;
              end
            end
          end else if (car_requests[car_floor]) begin
            open_door();
          end
        end
      end
      if (car_door > 0) car_door--;
    end
    // An idle car with a target and a closed door sets off.
    if (car_motion == MOT_IDLE && car_tv && car_door == 0) begin
      if (car_target > car_floor) car_motion = MOT_UP;
      else if (car_target < car_floor) car_motion = MOT_DOWN;
    end
    res.floor_now  = car_floor;
    res.motion     = car_motion;
    res.has_target = car_tv;
    res.target_now = car_tv ? car_target : '0;
    res.lamp       = car_lamp;
    res.door_open  = (car_door != 0);
    return res;
  endfunction

  // Offer one word, with random gaps unless the bench runs steady.
  task automatic send_word(input cmd_e cmd, input floor_t fl);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.pressed_floor <= fl;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_cars.push_back(advance_car(cmd, fl));
  endtask

  // Wait until every predicted word has come back and the pipeline is empty.
  task automatic settle_car();
    in_ch.valid <= 1'b0;
    while (expected_cars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the enable is lowered by the caller.
  task automatic write_reg(input logic [EFC_CFG_IDX_W-1:0] idx, input cnt_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_UP_BLINK:   timing.up_blink   = val;
      REG_DOWN_BLINK: timing.down_blink = val;
      REG_UP_FLOOR:   timing.up_floor   = val;
      REG_DOWN_FLOOR: timing.down_floor = val;
      REG_DOOR_WAIT:  timing.door_wait  = val;
      default: ;
    endcase
  endtask

  // Load all timing registers, then hit the unused indexes with junk.
  task automatic write_timing(input cnt_t ub, input cnt_t db, input cnt_t uf,
                              input cnt_t df, input cnt_t dw);
    write_reg(REG_UP_BLINK, ub);
    write_reg(REG_DOWN_BLINK, db);
    write_reg(REG_UP_FLOOR, uf);
    write_reg(REG_DOWN_FLOOR, df);
    write_reg(REG_DOOR_WAIT, dw);
    for (int i = CFG_IDX_SPARE; i <= CFG_IDX_TOP; i++) begin
      write_reg(EFC_CFG_IDX_W'(i), cnt_t'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_random_timing(input int unsigned max_blink, input int unsigned max_floor,
                                     input int unsigned max_door);
    write_timing(cnt_t'($urandom_range(1, max_blink)), cnt_t'($urandom_range(1, max_blink)),
                 cnt_t'($urandom_range(1, max_floor)), cnt_t'($urandom_range(1, max_floor)),
                 cnt_t'($urandom_range(0, max_door)));
  endtask

  // Mostly ticks so the car keeps moving, with presses of every kind mixed in.
  task automatic run_traffic(input int count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_word(CMD_TICK, floor_t'($urandom_range(0, FLOOR_CODE_MAX)));
      end else if (pick < 78) begin
        send_word(CMD_PRESS, car_floor);
      end else if (pick < 84) begin
        send_word(CMD_PRESS, floor_t'($urandom_range(FLOORS, FLOOR_CODE_MAX)));
      end else begin
        send_word(CMD_PRESS, floor_t'($urandom_range(0, FLOORS - 1)));
      end
    end
    settle_car();
  endtask

  // Reset timing first, then a long idle run that pins the blink counter
  // at its ceiling so the first tick of an upward trip toggles the lamp.
  task automatic test_counter_saturation();
    send_word(CMD_TICK, floor_t'(0));
    send_word(CMD_PRESS, floor_t'(12));
    send_word(CMD_TICK, floor_t'(FLOOR_CODE_MAX));
    settle_car();
    write_timing(EFC_CNT_MAX, 10'd1, 10'd3, EFC_CNT_MAX, 10'd0);
    repeat (1030) send_word(CMD_TICK, floor_t'($urandom_range(0, FLOOR_CODE_MAX)));
    send_word(CMD_PRESS, floor_t'(FLOORS - 1));
    while (car_tv || car_motion != MOT_IDLE) begin
      send_word(CMD_TICK, floor_t'($urandom_range(0, FLOOR_CODE_MAX)));
    end
    settle_car();
  endtask

  // Press rules: out of range, own floor idle and moving, target extension.
  task automatic test_press_rules();
    write_timing(10'd2, 10'd3, 10'd2, 10'd1, 10'd2);
    send_word(CMD_PRESS, floor_t'(FLOOR_CODE_MAX));
    send_word(CMD_PRESS, floor_t'(FLOORS));
    send_word(CMD_PRESS, car_floor);
    send_word(CMD_PRESS, floor_t'(5));
    send_word(CMD_PRESS, floor_t'(7));
    send_word(CMD_PRESS, floor_t'(3));
    repeat (3) send_word(CMD_TICK, floor_t'(9));
    send_word(CMD_PRESS, car_floor);
    repeat (4) send_word(CMD_TICK, floor_t'(0));
    send_word(CMD_PRESS, floor_t'(8));
    send_word(CMD_PRESS, floor_t'(0));
    repeat (6) send_word(CMD_TICK, floor_t'(10));
    settle_car();
  endtask

  // Random traffic over several timing settings, one stretch without gaps.
  task automatic test_random_traffic();
    write_random_timing(4, 6, 6);
    run_traffic(150);
    steady = 1'b1;
    write_random_timing(4, 6, 6);
    run_traffic(150);
    steady = 1'b0;
    write_timing(10'd1, EFC_CNT_MAX, 10'd1, 10'd2, EFC_CNT_MAX);
    run_traffic(100);
    write_timing(EFC_CNT_MAX, 10'd1, 10'd4, 10'd1, 10'd0);
    run_traffic(100);
    write_random_timing(40, 40, 40);
    run_traffic(120);
  endtask

  // Result side stalls at random unless the bench runs steady.
  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && (steady || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result word with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    car_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_cars.size() == 0) begin
        $error("result word with no prediction waiting");
        fail_count++;
      end else begin
        want = expected_cars.pop_front();
        if (out_ch.floor_now !== want.floor_now) begin
          $error("floor_now: expected %0d, got %0d", want.floor_now, out_ch.floor_now);
          fail_count++;
        end
        if (out_ch.motion !== want.motion) begin
          $error("motion: expected %0d, got %0d", want.motion, out_ch.motion);
          fail_count++;
        end
        if (out_ch.has_target !== want.has_target) begin
          $error("has_target: expected %0d, got %0d", want.has_target, out_ch.has_target);
          fail_count++;
        end
        if (out_ch.target_now !== want.target_now) begin
          $error("target_now: expected %0d, got %0d", want.target_now, out_ch.target_now);
          fail_count++;
        end
        if (out_ch.lamp !== want.lamp) begin
          $error("lamp: expected %0d, got %0d", want.lamp, out_ch.lamp);
          fail_count++;
        end
        if (out_ch.door_open !== want.door_open) begin
          $error("door_open: expected %0d, got %0d", want.door_open, out_ch.door_open);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_PRESS;
    in_ch.pressed_floor <= '0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_wdata_i         <= '0;
    timing.up_blink   = EFC_UP_BLINK_RST;
    timing.down_blink = EFC_DOWN_BLINK_RST;
    timing.up_floor   = EFC_UP_FLOOR_RST;
    timing.down_floor = EFC_DOWN_FLOOR_RST;
    timing.door_wait  = EFC_DOOR_WAIT_RST;
    car_floor    = '0;
    car_target   = '0;
    car_tv       = 1'b0;
    car_requests = '0;
    car_motion   = MOT_IDLE;
    car_blink    = '0;
    car_travel   = '0;
    car_door     = '0;
    car_lamp     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_counter_saturation();
    test_press_rules();
    test_random_traffic();

    if (fail_count == 0 && expected_cars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/efc_pkg.sv
hw/rtl/efc_if.sv
hw/rtl/efc_cfg_regs.sv
hw/rtl/efc_step.sv
hw/rtl/elevator_floor_controller.sv
bench/elevator_floor_controller_tb.sv
